/* design/fdr_pkg.sv */
package fdr_pkg;

  localparam int FUNC_W   = 3;
  localparam int ADDR_W   = 32;
  localparam int LEN_W    = 32;
  localparam int SERIAL_W = 16;
  localparam int USED_W   = 5;
  localparam int SUM_W    = 38;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 64;

  // serial keys wrap below this value, trimmed to a multiple of the slot count
  localparam int SERIAL_MAX = 16'hFFFF;

  // register index is the 8-byte word number of paddr
  localparam int REG_SEL_BIT = 3;
  localparam logic REG_POLICY  = 1'b0;
  localparam logic REG_MAX_MEM = 1'b1;

  localparam logic [FUNC_W-1:0] FUNC_ENQ   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEQ   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOK  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_TRIM  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH = 3'd4;

  localparam logic KIND_NOTICE = 1'b0;
  localparam logic KIND_DONE   = 1'b1;
  localparam logic ST_OK       = 1'b0;
  localparam logic ST_FAIL     = 1'b1;

  typedef enum logic [2:0] {
    OP_ENQ,
    OP_ENQ_ZERO,
    OP_DEQ,
    OP_LOOKUP,
    OP_TRIM,
    OP_FLUSH,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [ADDR_W-1:0]   frame_addr;
    logic [LEN_W-1:0]    frame_len;
    logic                notify;
    logic [SERIAL_W-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic             policy_mode;
    logic [SUM_W-1:0] max_mem;
  } cfg_t;

  typedef struct packed {
    logic                kind;
    logic                status;
    logic [SERIAL_W-1:0] serial;
    logic [ADDR_W-1:0]   addr;
    logic [LEN_W-1:0]    len;
    logic [USED_W-1:0]   used;
    logic [SUM_W-1:0]    sum;
    logic                last;
  } rsp_t;

endpackage

/* design/fdr_if.sv */
interface fdr_cmd_if import fdr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [ADDR_W-1:0]   frame_addr;
  logic [LEN_W-1:0]    frame_len;
  logic                notify_on_release;
  logic [SERIAL_W-1:0] key_serial;

  modport source (
    output valid, func, frame_addr, frame_len, notify_on_release, key_serial,
    input  ready
  );
  modport sink (
    input  valid, func, frame_addr, frame_len, notify_on_release, key_serial,
    output ready
  );
endinterface

interface fdr_rsp_if import fdr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic                status;
  logic [SERIAL_W-1:0] serial_out;
  logic [ADDR_W-1:0]   addr_out;
  logic [LEN_W-1:0]    len_out;
  logic [USED_W-1:0]   used_count;
  logic [SUM_W-1:0]    memory_sum;
  logic                last;

  modport source (
    output valid, kind, status, serial_out, addr_out, len_out, used_count,
           memory_sum, last,
    input  ready
  );
  modport sink (
    input  valid, kind, status, serial_out, addr_out, len_out, used_count,
           memory_sum, last,
    output ready
  );
endinterface

/* design/fdr_front.sv */
module fdr_front import fdr_pkg::*; #(
  parameter int SLOTS = 17,
  localparam int IDX_W = $clog2(SLOTS)
) (
  input  logic             clk,
  input  logic             rst,
  fdr_cmd_if.sink          cmd,
  output logic             push,
  output cmd_t             push_cmd,
  output logic [IDX_W-1:0] push_slot,
  input  logic             full
);

  // floor(2^32 / SLOTS): quotient estimate is exact or one low
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / SLOTS);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t             state, state_next;
  cmd_t                item;
  op_t                 op_dec;
  logic [SERIAL_W-1:0] quot;
  logic [47:0]         prod;
  logic [SERIAL_W-1:0] qs;
  logic [SERIAL_W-1:0] rem;
  logic [IDX_W:0]      rem_n;
  logic [IDX_W:0]      slot_wide;

  assign cmd.ready = (state == F_IDLE);

  always_comb begin
    case (cmd.func)
      FUNC_ENQ:   op_dec = (cmd.frame_len == '0) ? OP_ENQ_ZERO : OP_ENQ;
      FUNC_DEQ:   op_dec = OP_DEQ;
      FUNC_LOOK:  op_dec = OP_LOOKUP;
      FUNC_TRIM:  op_dec = OP_TRIM;
      FUNC_FLUSH: op_dec = OP_FLUSH;
      default:    op_dec = OP_BAD;
    endcase
  end

  assign prod = item.key * RECIP;

  // key mod SLOTS from the registered quotient, one correction step
  always_comb begin
    qs        = SERIAL_W'(quot * SLOTS);
    rem       = item.key - qs;
    rem_n     = rem[IDX_W:0];
    slot_wide = (rem_n >= (IDX_W+1)'(SLOTS)) ? rem_n - (IDX_W+1)'(SLOTS) : rem_n;
  end

  assign push_slot = slot_wide[IDX_W-1:0];
  assign push_cmd  = item;
  assign push      = (state == F_PUSH) && !full;

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (cmd.valid) state_next = F_MUL;
      F_MUL:   state_next = F_PUSH;
      F_PUSH:  if (!full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && cmd.valid) begin
      item.op         <= op_dec;
      item.frame_addr <= cmd.frame_addr;
      item.frame_len  <= cmd.frame_len;
      item.notify     <= cmd.notify_on_release;
      item.key        <= cmd.key_serial;
    end
    if (state == F_MUL) begin
      quot <= prod[47:32];
    end
  end

endmodule

/* design/fdr_cmd_q.sv */
module fdr_cmd_q import fdr_pkg::*; #(
  parameter int IDX_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cmd_t             push_cmd,
  input  logic [IDX_W-1:0] push_slot,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output cmd_t             head_cmd,
  output logic [IDX_W-1:0] head_slot
);

  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  cmd_t             cmd_mem  [QDEPTH];
  logic [IDX_W-1:0] slot_mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(QDEPTH));
  assign empty     = (count == '0);
  assign head_cmd  = cmd_mem[rd_ptr];
  assign head_slot = slot_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_mem[wr_ptr]  <= push_cmd;
      slot_mem[wr_ptr] <= push_slot;
    end
  end

endmodule

/* design/fdr_back.sv */
module fdr_back import fdr_pkg::*; #(
  parameter int CAPACITY = 16,
  localparam int SLOTS = CAPACITY + 1,
  localparam int IDX_W = $clog2(SLOTS)
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             empty,
  output logic             pop,
  input  cmd_t             head_cmd,
  input  logic [IDX_W-1:0] head_slot,
  fdr_rsp_if.source        rsp
);

  localparam int CNT_W        = $clog2(CAPACITY + 1);
  localparam int SERIAL_LIMIT = (SERIAL_MAX / SLOTS) * SLOTS;

  typedef enum logic [5:0] {
    B_IDLE  = 6'b000001,
    B_CHECK = 6'b000010,
    B_EVICT = 6'b000100,
    B_STORE = 6'b001000,
    B_LOOK  = 6'b010000,
    B_DONE  = 6'b100000
  } bstate_t;

  bstate_t             state, state_next;
  cmd_t                cur;
  logic [IDX_W-1:0]    slot;
  logic                phase;
  logic [IDX_W-1:0]    head, tail;
  logic [CNT_W-1:0]    occ;
  logic [SUM_W-1:0]    byte_total;
  logic [SERIAL_W-1:0] next_serial;
  logic [SERIAL_W-1:0] done_serial;
  logic                look_hit;

  logic [ADDR_W-1:0]   addr_mem   [SLOTS];
  logic [LEN_W-1:0]    len_mem    [SLOTS];
  logic [SERIAL_W-1:0] serial_mem [SLOTS];
  logic                notify_mem [SLOTS];

  logic [IDX_W-1:0]    rd_idx;
  logic [ADDR_W-1:0]   rd_addr;
  logic [LEN_W-1:0]    rd_len;
  logic [SERIAL_W-1:0] rd_serial;
  logic                rd_notify;

  rsp_t                out_reg, out_next;
  logic                out_valid, out_load, out_free;
  logic                policy_hit, evict_go, live;
  logic [IDX_W-1:0]    newest;
  logic [CNT_W-1:0]    occ_dec;
  logic [SUM_W-1:0]    sum_dec;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [USED_W-1:0] used_of(input logic [CNT_W-1:0] c);
    logic [CNT_W+USED_W-1:0] w;
    w = {{USED_W{1'b0}}, c};
    return w[USED_W-1:0];
  endfunction

  assign out_free   = !out_valid || rsp.ready;
  assign policy_hit = cfg.policy_mode && (byte_total > cfg.max_mem) && (occ != '0);
  assign evict_go   = (state == B_EVICT) && (!rd_notify || out_free);
  assign occ_dec    = occ - 1'b1;
  assign sum_dec    = byte_total - {{(SUM_W-LEN_W){1'b0}}, rd_len};
  assign rd_idx     = (cur.op == OP_LOOKUP) ? slot : tail;

  // live range runs from tail up to the slot before head, wrapping
  always_comb begin
    newest = (head == '0) ? IDX_W'(CAPACITY) : head - 1'b1;
    if (occ == '0) begin
      live = 1'b0;
    end else if (newest >= tail) begin
      live = (slot >= tail) && (slot <= newest);
    end else begin
      live = (slot <= newest) || (slot >= tail);
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    out_load   = 1'b0;
    out_next   = '0;
    case (state)
      B_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = B_CHECK;
        end
      end
      B_CHECK: begin
        case (cur.op)
          OP_ENQ: begin
            if (!phase) begin
              state_next = (occ >= CNT_W'(CAPACITY)) ? B_EVICT : B_STORE;
            end else begin
              state_next = policy_hit ? B_EVICT : B_DONE;
            end
          end
          OP_DEQ:    state_next = (!phase && occ != '0) ? B_EVICT : B_DONE;
          OP_LOOKUP: state_next = B_LOOK;
          OP_TRIM:   state_next = policy_hit ? B_EVICT : B_DONE;
          OP_FLUSH:  state_next = (occ != '0) ? B_EVICT : B_DONE;
          default:   state_next = B_DONE;
        endcase
      end
      B_EVICT: begin
        if (evict_go) begin
          state_next = B_CHECK;
          if (rd_notify) begin
            out_load        = 1'b1;
            out_next.kind   = KIND_NOTICE;
            out_next.status = ST_OK;
            out_next.serial = rd_serial;
            out_next.addr   = rd_addr;
            out_next.len    = rd_len;
            out_next.used   = used_of(occ_dec);
            out_next.sum    = sum_dec;
            out_next.last   = 1'b0;
          end
        end
      end
      B_STORE: state_next = B_CHECK;
      B_LOOK:  state_next = B_DONE;
      B_DONE: begin
        if (out_free) begin
          state_next    = B_IDLE;
          out_load      = 1'b1;
          out_next.kind = KIND_DONE;
          out_next.used = used_of(occ);
          out_next.sum  = byte_total;
          out_next.last = 1'b1;
          case (cur.op)
            OP_ENQ: begin
              out_next.status = ST_OK;
              out_next.serial = done_serial;
            end
            OP_DEQ:  out_next.status = phase ? ST_OK : ST_FAIL;
            OP_LOOKUP: begin
              out_next.status = look_hit ? ST_OK : ST_FAIL;
              out_next.addr   = look_hit ? rd_addr : '0;
              out_next.len    = look_hit ? rd_len : '0;
            end
            OP_TRIM:  out_next.status = ST_OK;
            OP_FLUSH: out_next.status = ST_OK;
            default:  out_next.status = ST_FAIL;
          endcase
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      head        <= '0;
      tail        <= '0;
      occ         <= '0;
      byte_total  <= '0;
      next_serial <= '0;
      phase       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        phase <= 1'b0;
      end
      if (evict_go) begin
        tail       <= wrap_inc(tail);
        occ        <= occ_dec;
        byte_total <= sum_dec;
        if (cur.op == OP_DEQ) begin
          phase <= 1'b1;
        end
      end
      if (state == B_STORE) begin
        head        <= wrap_inc(head);
        occ         <= occ + 1'b1;
        byte_total  <= byte_total + {{(SUM_W-LEN_W){1'b0}}, cur.frame_len};
        next_serial <= (next_serial == SERIAL_W'(SERIAL_LIMIT - 1)) ? '0
                                                                     : next_serial + 1'b1;
        phase       <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur  <= head_cmd;
      slot <= head_slot;
    end
    if (state == B_STORE) begin
      addr_mem[head]   <= cur.frame_addr;
      len_mem[head]    <= cur.frame_len;
      serial_mem[head] <= next_serial;
      notify_mem[head] <= cur.notify;
      done_serial      <= next_serial;
    end
    rd_addr   <= addr_mem[rd_idx];
    rd_len    <= len_mem[rd_idx];
    rd_serial <= serial_mem[rd_idx];
    rd_notify <= notify_mem[rd_idx];
    if (state == B_LOOK) begin
      look_hit <= live && (rd_serial == cur.key);
    end
    if (out_load) begin
      out_reg <= out_next;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.kind       = out_reg.kind;
  assign rsp.status     = out_reg.status;
  assign rsp.serial_out = out_reg.serial;
  assign rsp.addr_out   = out_reg.addr;
  assign rsp.len_out    = out_reg.len;
  assign rsp.used_count = out_reg.used;
  assign rsp.memory_sum = out_reg.sum;
  assign rsp.last       = out_reg.last;

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    (occ == '0) |-> (byte_total == '0))
    else $error("byte total nonzero on empty ring");

  a_ring_span: assert property (@(posedge clk) disable iff (rst)
    (int'(tail) + int'(occ) == int'(head)) || (int'(tail) + int'(occ) == int'(head) + SLOTS))
    else $error("head, tail and occupancy disagree");

  a_store_room: assert property (@(posedge clk) disable iff (rst)
    (state == B_STORE) |-> (occ < CNT_W'(CAPACITY)))
    else $error("store into a full ring");

endmodule

/* design/frame_descriptor_ring_with_keys_unit.sv */
// Frame descriptor ring with serial keys and a drop-oldest byte budget.
// cmd channel: one beat per command (enqueue, dequeue, lookup, trim, flush),
// taken when valid and ready are high. rsp channel: zero or more release
// notices (kind 0), then one completion (kind 1, last 1) per command.
// APB port: policy_mode at 0x0, max_mem at 0x8; write only while idle.
// The front end captures a command, runs a reciprocal multiply for the
// key-to-slot mapping and pushes it into a 2-entry queue; cmd ready is
// low during the multiply and the push, which waits while the queue is
// full. The back-end sequencer pops a command, checks it and completes
// it; a lookup adds a look step, an enqueue adds a store and a second
// check, and each evicted entry adds an evict step and a check.
// The back-end sequencer and its single ring-memory read port set the
// throughput; it works on one command at a time while the queue holds more.
// Reset empties the ring, zeroes the serial counter and both registers;
// stored descriptors are not cleared. If rsp stalls, the output register
// holds its beat, the back end stops at its next result and the queue and
// front end fill before cmd ready drops for good.
module frame_descriptor_ring_with_keys_unit import fdr_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  fdr_cmd_if.sink            cmd,
  fdr_rsp_if.source          rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int SLOTS = CAPACITY + 1;
  localparam int IDX_W = $clog2(SLOTS);

  cfg_t             cfg;
  logic             cfg_wr;
  logic             push, full, pop, empty;
  cmd_t             push_cmd, head_cmd;
  logic [IDX_W-1:0] push_slot, head_slot;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      case (paddr[REG_SEL_BIT])
        REG_POLICY:  cfg.policy_mode <= pwdata[0];
        REG_MAX_MEM: cfg.max_mem     <= pwdata[SUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[REG_SEL_BIT])
      REG_POLICY:  prdata = {{(PDATA_W-1){1'b0}}, cfg.policy_mode};
      REG_MAX_MEM: prdata = {{(PDATA_W-SUM_W){1'b0}}, cfg.max_mem};
      default:     prdata = '0;
    endcase
  end

  fdr_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_slot (push_slot),
    .full      (full)
  );

  fdr_cmd_q #(
    .IDX_W (IDX_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_slot (push_slot),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head_cmd  (head_cmd),
    .head_slot (head_slot)
  );

  fdr_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .empty     (empty),
    .pop       (pop),
    .head_cmd  (head_cmd),
    .head_slot (head_slot),
    .rsp       (rsp)
  );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import fdr_pkg::*;

  localparam int CAPACITY = 16;
  localparam int SLOTS = CAPACITY + 1;
  localparam int SERIAL_SPAN = (SERIAL_MAX / SLOTS) * SLOTS;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam logic [FUNC_W-1:0] FUNC_RSVD5 = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_RSVD7 = 3'd7;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [ADDR_W-1:0]   addr;
    logic [LEN_W-1:0]    len;
    logic                notify;
    logic [SERIAL_W-1:0] key;
  } frame_cmd_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  fdr_cmd_if cmd ();
  fdr_rsp_if rsp ();

  frame_descriptor_ring_with_keys_unit #(.CAPACITY(CAPACITY)) uut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // mirror of the ring
  logic [ADDR_W-1:0]   ring_addr   [SLOTS];
  logic [LEN_W-1:0]    ring_len    [SLOTS];
  logic [SERIAL_W-1:0] ring_serial [SLOTS];
  logic                ring_notify [SLOTS];
  int unsigned         ring_head;
  int unsigned         ring_tail;
  int unsigned         ring_count;
  int unsigned         serial_next;
  logic [SUM_W-1:0]    ring_bytes;
  logic                drop_mode;
  logic [SUM_W-1:0]    byte_budget;

  rsp_t        due_results[$];
  int unsigned errors;
  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  int unsigned hold_off_left;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void note_result(logic kind, logic status, logic [SERIAL_W-1:0] serial,
                                      logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len,
                                      logic last);
    rsp_t r;
    r.kind   = kind;
    r.status = status;
    r.serial = serial;
    r.addr   = addr;
    r.len    = len;
    r.used   = USED_W'(ring_count);
    r.sum    = ring_bytes;
    r.last   = last;
    due_results.push_back(r);
  endfunction

  function automatic bit drop_oldest();
    int unsigned t;
    t = ring_tail;
    if (ring_count == 0) return 1'b0;
    ring_tail = (t + 1 == SLOTS) ? 0 : t + 1;
    ring_count--;
    ring_bytes = ring_bytes - SUM_W'(ring_len[t]);
    if (ring_notify[t])
      note_result(KIND_NOTICE, ST_OK, ring_serial[t], ring_addr[t], ring_len[t], 1'b0);
    return 1'b1;
  endfunction

  function automatic void enforce_budget();
    if (drop_mode)
      while (ring_bytes > byte_budget && drop_oldest()) ;
  endfunction

  function automatic bit slot_is_live(int unsigned idx);
    int unsigned newest;
    if (ring_count == 0) return 1'b0;
    newest = (ring_head == 0) ? CAPACITY : ring_head - 1;
    if (newest >= ring_tail) return idx >= ring_tail && idx <= newest;
    return idx <= newest || idx >= ring_tail;
  endfunction

  function automatic void compute_ring_results(frame_cmd_t c);
    int unsigned idx;
    logic [SERIAL_W-1:0] s;
    bit ok;
    case (c.func)
      FUNC_ENQ: begin
        if (c.len == '0) begin
          note_result(KIND_DONE, ST_FAIL, '0, '0, '0, 1'b1);
        end else begin
          if (ring_count >= CAPACITY) void'(drop_oldest());
          s = SERIAL_W'(serial_next);
          ring_addr[ring_head]   = c.addr;
          ring_len[ring_head]    = c.len;
          ring_serial[ring_head] = s;
          ring_notify[ring_head] = c.notify;
          serial_next = (serial_next + 1 >= SERIAL_SPAN) ? 0 : serial_next + 1;
          ring_head = (ring_head + 1 == SLOTS) ? 0 : ring_head + 1;
          ring_count++;
          ring_bytes = ring_bytes + SUM_W'(c.len);
          // the new entry may go too; completion still reports its serial
          enforce_budget();
          note_result(KIND_DONE, ST_OK, s, '0, '0, 1'b1);
        end
      end
      FUNC_DEQ: begin
        ok = drop_oldest();
        note_result(KIND_DONE, ok ? ST_OK : ST_FAIL, '0, '0, '0, 1'b1);
      end
      FUNC_LOOK: begin
        idx = c.key % SLOTS;
        if (slot_is_live(idx) && ring_serial[idx] == c.key)
          note_result(KIND_DONE, ST_OK, '0, ring_addr[idx], ring_len[idx], 1'b1);
        else
          note_result(KIND_DONE, ST_FAIL, '0, '0, '0, 1'b1);
      end
      FUNC_TRIM: begin
        enforce_budget();
        note_result(KIND_DONE, ST_OK, '0, '0, '0, 1'b1);
      end
      FUNC_FLUSH: begin
        while (drop_oldest()) ;
        note_result(KIND_DONE, ST_OK, '0, '0, '0, 1'b1);
      end
      default: note_result(KIND_DONE, ST_FAIL, '0, '0, '0, 1'b1);
    endcase
  endfunction

  function automatic frame_cmd_t make_cmd(logic [FUNC_W-1:0] func, logic [ADDR_W-1:0] addr,
                                          logic [LEN_W-1:0] len, logic notify,
                                          logic [SERIAL_W-1:0] key);
    frame_cmd_t c;
    c.func   = func;
    c.addr   = addr;
    c.len    = len;
    c.notify = notify;
    c.key    = key;
    return c;
  endfunction

  function automatic frame_cmd_t random_frame_cmd(bit big_lengths);
    frame_cmd_t c;
    int unsigned pick;
    pick     = $urandom_range(99, 0);
    c.addr   = $urandom();
    c.notify = 1'($urandom_range(1, 0));
    c.key    = SERIAL_W'($urandom());
    case ($urandom_range(9, 0))
      0:       c.len = $urandom();
      1:       c.len = LEN_MAX - LEN_W'($urandom_range(3, 0));
      2:       c.len = $urandom_range(16, 1);
      default: c.len = big_lengths ? ($urandom() | 32'h4000_0000) : $urandom_range(1200, 1);
    endcase
    if (c.len == '0) c.len = 1;
    if (pick < 45) begin
      c.func = FUNC_ENQ;
    end else if (pick < 48) begin
      c.func = FUNC_ENQ;
      c.len  = '0;
    end else if (pick < 63) begin
      c.func = FUNC_DEQ;
    end else if (pick < 90) begin
      c.func = FUNC_LOOK;
      case ($urandom_range(3, 0))
        0: ;
        // recently issued serials, some of them already gone
        1: c.key = SERIAL_W'(serial_next - $urandom_range(CAPACITY + 4, 1));
        default: begin
          if (ring_count != 0)
            c.key = ring_serial[(ring_tail + $urandom_range(ring_count - 1, 0)) % SLOTS];
        end
      endcase
    end else if (pick < 95) begin
      c.func = FUNC_TRIM;
    end else if (pick < 97) begin
      c.func = FUNC_FLUSH;
    end else begin
      case ($urandom_range(2, 0))
        0:       c.func = FUNC_RSVD5;
        1:       c.func = FUNC_RSVD6;
        default: c.func = FUNC_RSVD7;
      endcase
    end
    return c;
  endfunction

  task automatic send_frame_cmd(frame_cmd_t c);
    @(negedge clk);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      cmd.valid <= 1'b0;
      @(negedge clk);
    end
    cmd.valid             <= 1'b1;
    cmd.func              <= c.func;
    cmd.frame_addr        <= c.addr;
    cmd.frame_len         <= c.len;
    cmd.notify_on_release <= c.notify;
    cmd.key_serial        <= c.key;
    do @(posedge clk); while (!cmd.ready);
    compute_ring_results(c);
  endtask

  task automatic drain_results();
    @(negedge clk);
    cmd.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic reg_sel, logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] readback;
    readback = (reg_sel == REG_POLICY) ? PDATA_W'(value[0]) : PDATA_W'(value[SUM_W-1:0]);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= PADDR_W'(reg_sel) << REG_SEL_BIT;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (reg_sel == REG_POLICY) drop_mode = value[0];
    else byte_budget = value[SUM_W-1:0];
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== readback) begin
      errors++;
      $display("%0t: register %0d readback, expected 0x%0h, got 0x%0h",
               $time, reg_sel, readback, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_policy(logic mode, logic [SUM_W-1:0] budget);
    drain_results();
    write_reg(REG_POLICY, PDATA_W'(mode));
    write_reg(REG_MAX_MEM, PDATA_W'(budget));
  endtask

  task automatic test_empty_ring();
    send_frame_cmd(make_cmd(FUNC_DEQ, '0, '0, 1'b0, '0));
    send_frame_cmd(make_cmd(FUNC_LOOK, '0, '0, 1'b0, '0));
    send_frame_cmd(make_cmd(FUNC_LOOK, '0, '0, 1'b0, SERIAL_W'(SERIAL_MAX)));
    send_frame_cmd(make_cmd(FUNC_TRIM, '0, '0, 1'b0, '0));
    send_frame_cmd(make_cmd(FUNC_FLUSH, '0, '0, 1'b0, '0));
    send_frame_cmd(make_cmd(FUNC_ENQ, '1, '0, 1'b1, '1));
  endtask

  task automatic test_bad_func();
    send_frame_cmd(make_cmd(FUNC_RSVD5, $urandom(), $urandom(), 1'b1, '1));
    send_frame_cmd(make_cmd(FUNC_RSVD6, $urandom(), $urandom(), 1'b0, '0));
    send_frame_cmd(make_cmd(FUNC_RSVD7, $urandom(), $urandom(), 1'b1, '1));
  endtask

  // the last enqueue lands on a full ring and pushes out serial 0
  task automatic test_full_ring();
    int i;
    send_frame_cmd(make_cmd(FUNC_ENQ, '1, LEN_MAX, 1'b1, '0));
    for (i = 1; i <= CAPACITY; i++)
      send_frame_cmd(make_cmd(FUNC_ENQ, $urandom(), LEN_W'(i * 100 + 1), i[0], '0));
    send_frame_cmd(make_cmd(FUNC_LOOK, '0, '0, 1'b0, '0));
    send_frame_cmd(make_cmd(FUNC_LOOK, '0, '0, 1'b0, SERIAL_W'(CAPACITY)));
  endtask

  task automatic test_policy();
    send_frame_cmd(make_cmd(FUNC_TRIM, '0, '0, 1'b0, '0));
    set_policy(1'b1, SUM_W'(4000));
    send_frame_cmd(make_cmd(FUNC_TRIM, '0, '0, 1'b0, '0));
    send_frame_cmd(make_cmd(FUNC_ENQ, $urandom(), LEN_W'(700), 1'b1, '0));
    send_frame_cmd(make_cmd(FUNC_DEQ, '0, '0, 1'b0, '0));
    send_frame_cmd(make_cmd(FUNC_FLUSH, '0, '0, 1'b0, '0));
    // zero budget: the new entry is dropped right after it is stored
    set_policy(1'b1, '0);
    send_frame_cmd(make_cmd(FUNC_ENQ, $urandom(), LEN_W'(5), 1'b1, '0));
    send_frame_cmd(make_cmd(FUNC_DEQ, '0, '0, 1'b0, '0));
  endtask

  task automatic test_random_traffic(int unsigned count, int unsigned snd_pct,
                                     int unsigned rcv_pct, logic mode,
                                     logic [SUM_W-1:0] budget, bit big_lengths);
    set_policy(mode, budget);
    sender_idle_pct   = snd_pct;
    receiver_idle_pct = rcv_pct;
    repeat (count) send_frame_cmd(random_frame_cmd(big_lengths));
  endtask

  task automatic test_backpressure();
    int i;
    set_policy(1'b0, SUM_MAX);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    @(posedge clk);
    hold_off_left = HOLD_OFF_CYCLES;
    for (i = 0; i < 30; i++)
      send_frame_cmd(make_cmd((i == 20) ? FUNC_FLUSH : FUNC_ENQ, $urandom(),
                              LEN_W'($urandom_range(5000, 1)), 1'b1, '0));
  endtask

  // live serials must hit; keys that map to a live slot but carry another serial must miss
  task automatic test_key_alias();
    int unsigned base;
    set_policy(1'b0, SUM_MAX);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    base = serial_next;
    repeat (6)
      send_frame_cmd(make_cmd(FUNC_ENQ, $urandom(), LEN_W'($urandom_range(4096, 1)), 1'b1,
                              '0));
    send_frame_cmd(make_cmd(FUNC_LOOK, '0, '0, 1'b0, SERIAL_W'(base)));
    send_frame_cmd(make_cmd(FUNC_LOOK, '0, '0, 1'b0, SERIAL_W'(base + SLOTS)));
    send_frame_cmd(make_cmd(FUNC_LOOK, '0, '0, 1'b0, SERIAL_W'(base + 5)));
    send_frame_cmd(make_cmd(FUNC_LOOK, '0, '0, 1'b0, SERIAL_W'(base + 6)));
    send_frame_cmd(make_cmd(FUNC_LOOK, '0, '0, 1'b0, SERIAL_W'(base - SLOTS)));
    send_frame_cmd(make_cmd(FUNC_FLUSH, '0, '0, 1'b0, '0));
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(negedge clk) begin
    if (hold_off_left != 0) begin
      rsp.ready <= 1'b0;
      hold_off_left--;
    end else begin
      rsp.ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected, got kind %0d serial 0x%0h last %0d",
                 $time, rsp.kind, rsp.serial_out, rsp.last);
      end else begin
        want = due_results.pop_front();
        check_field("kind", 64'(want.kind), 64'(rsp.kind));
        check_field("status", 64'(want.status), 64'(rsp.status));
        check_field("serial_out", 64'(want.serial), 64'(rsp.serial_out));
        check_field("addr_out", 64'(want.addr), 64'(rsp.addr_out));
        check_field("len_out", 64'(want.len), 64'(rsp.len_out));
        check_field("used_count", 64'(want.used), 64'(rsp.used_count));
        check_field("memory_sum", 64'(want.sum), 64'(rsp.memory_sum));
        check_field("last", 64'(want.last), 64'(rsp.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    cmd.valid             = 1'b0;
    cmd.func              = FUNC_ENQ;
    cmd.frame_addr        = '0;
    cmd.frame_len         = '0;
    cmd.notify_on_release = 1'b0;
    cmd.key_serial        = '0;
    rsp.ready             = 1'b0;
    errors                = 0;
    quiet_cycles          = 0;
    hold_off_left         = 0;
    sender_idle_pct       = 8;
    receiver_idle_pct     = 77;
    ring_head             = 0;
    ring_tail             = 0;
    ring_count            = 0;
    serial_next           = 0;
    ring_bytes            = '0;
    drop_mode             = 1'b0;
    byte_budget           = '0;
    for (int k = 0; k < SLOTS; k++) begin
      ring_addr[k]   = '0;
      ring_len[k]    = '0;
      ring_serial[k] = '0;
      ring_notify[k] = 1'b0;
    end
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_empty_ring();
    test_bad_func();
    test_full_ring();
    test_policy();
    test_random_traffic(100, 8, 77, 1'b1, SUM_W'(3000), 1'b0);
    test_random_traffic(100, 77, 8, 1'b0, SUM_MAX, 1'b0);
    test_random_traffic(100, 0, 0, 1'b1, SUM_W'(64'd3 << 32), 1'b1);
    test_backpressure();
    test_key_alias();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
